### hdl/bgs_pkg.sv
`timescale 1ns / 1ps

package bgs_pkg;

	localparam int MV_W        = 13;
	localparam int PCT_W       = 7;
	localparam int TIME_W      = 32;
	localparam int WEIGHT_W    = 16;
	localparam int HOLD_W      = 16;
	localparam int FRAC_BITS   = 16;
	localparam int WEIGHT_FRAC = 16;
	localparam int SV_W        = MV_W + FRAC_BITS;
	localparam int PROD_W      = SV_W + WEIGHT_W;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int LVL_N       = 9;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_USB_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 2'd2;

	localparam logic [WEIGHT_W-1:0] WEIGHT_RST    = 16'd5243;
	localparam logic [MV_W-1:0]     USB_LIMIT_RST = 13'd4200;
	localparam logic [HOLD_W-1:0]   HOLD_RST      = 16'd2000;
	localparam logic [PCT_W-1:0]    PCT_RST       = 7'd100;
	localparam logic [PCT_W-1:0]    PCT_FLOOR     = 7'd5;

	// lipo discharge curve, highest level first
	localparam logic [MV_W-1:0] LVL_MV [LVL_N] = '{
		13'd4200, 13'd4100, 13'd4000, 13'd3900, 13'd3800,
		13'd3700, 13'd3600, 13'd3500, 13'd3400
	};
	localparam logic [PCT_W-1:0] LVL_PCT [LVL_N] = '{
		7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd30, 7'd20, 7'd10
	};

	typedef struct packed {
		logic [MV_W-1:0]   battery_mv;
		logic              charger_active;
		logic [TIME_W-1:0] now_ms;
	} sample_t;

	typedef struct packed {
		logic [PCT_W-1:0] shown_percent;
		logic             charging_shown;
		logic [MV_W-1:0]  smoothed_mv;
	} result_t;

	// first level reached from the top wins
	function automatic logic [PCT_W-1:0] lipo_percent(input logic [MV_W-1:0] mv);
		logic [PCT_W-1:0] pct;
		pct = PCT_FLOOR;
		for (int i = LVL_N - 1; i >= 0; i--) begin
			if (mv >= LVL_MV[i]) pct = LVL_PCT[i];
		end
		return pct;
	endfunction

endpackage

### hdl/battery_gauge_smoother.sv
`timescale 1ns / 1ps

// battery gauge: exponential voltage smoothing, charge detect, percent slew
// a result passes the stage 1, stage 2 and output registers after its sample transfer
// throughput: one sample per cycle while result_stall is low, set by the combinational average and slew updates
// reset: weight 5243, usb limit 4200 mv, hold 2000 ms, average unseeded,
// shown percent 100, not charging, disconnect time 0, pipeline empty
module battery_gauge_smoother (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  bgs_pkg::sample_t                    sample,
	output logic                                result_valid,
	input  logic                                result_stall,
	output bgs_pkg::result_t                    result,
	input  logic                                cfg_we,
	input  logic [bgs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bgs_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import bgs_pkg::*;

	// stage 2 carries what the percent slew needs
	typedef struct packed {
		logic [MV_W-1:0] mv;
		logic            charging;
		logic            hold;
	} gauge_t;

	// configuration registers
	logic [WEIGHT_W-1:0] weight_q;
	logic [MV_W-1:0]     usb_limit_q;
	logic [HOLD_W-1:0]   hold_q;

	// gauge state
	logic [SV_W-1:0]   sv_q;
	logic [PCT_W-1:0]  pct_q;
	logic              chg_q;
	logic [TIME_W-1:0] stamp_q;

	// pipeline
	sample_t samp_s1;
	logic    valid_s1;
	gauge_t  gauge_s2;
	logic    valid_s2;
	result_t result_q;
	logic    result_valid_q;

	logic out_load, adv_s2, adv_s1, take;

	// each stage moves on when the next one is empty or moving, so bubbles collapse
	assign out_load     = !result_valid_q || !result_stall;
	assign adv_s2       = valid_s2 && out_load;
	assign adv_s1       = valid_s1 && (!valid_s2 || adv_s2);
	assign sample_stall = valid_s1 && !adv_s1;
	assign take         = sample_valid && !sample_stall;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// ---- stage 1: charge detect, average update, hold window ----
	logic              chg_now;
	logic [SV_W-1:0]   target, sv_base, mag, step, sv_next;
	logic              up;
	logic [PROD_W-1:0] prod, prod_rnd;
	logic [TIME_W-1:0] stamp_next, elapsed;
	logic              hold_now;

	assign chg_now = samp_s1.charger_active || (samp_s1.battery_mv > usb_limit_q);
	assign target  = {samp_s1.battery_mv, {FRAC_BITS{1'b0}}};
	// a zero average means unseeded, so the sample seeds it
	assign sv_base = (sv_q == '0) ? target : sv_q;
	assign up      = target >= sv_base;
	assign mag     = up ? (target - sv_base) : (sv_base - target);
	assign prod    = PROD_W'(mag) * PROD_W'(weight_q);
	// downward steps round up in magnitude, giving a floor on the signed product
	assign prod_rnd = up ? prod : (prod + PROD_W'({WEIGHT_FRAC{1'b1}}));
	assign step     = prod_rnd[PROD_W-1:WEIGHT_FRAC];
	assign sv_next  = up ? (sv_base + step) : (sv_base - step);

	// charge just ended: stamp the time of this sample
	assign stamp_next = (chg_q && !chg_now) ? samp_s1.now_ms : stamp_q;
	assign elapsed    = samp_s1.now_ms - stamp_next;
	assign hold_now   = !chg_now && (elapsed[TIME_W-1:HOLD_W] == '0)
	                    && (elapsed[HOLD_W-1:0] < hold_q);

	// ---- stage 2: slew one step toward the table value unless in the hold window ----
	logic [PCT_W-1:0] pct_goal, pct_next;

	assign pct_goal = lipo_percent(gauge_s2.mv);

	always_comb begin
		pct_next = pct_q;
		if (!gauge_s2.hold) begin
			if (pct_goal > pct_q) pct_next = pct_q + PCT_W'(1);
			else if (pct_goal < pct_q) pct_next = pct_q - PCT_W'(1);
		end
	end

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q       <= WEIGHT_RST;
			usb_limit_q    <= USB_LIMIT_RST;
			hold_q         <= HOLD_RST;
			sv_q           <= '0;
			pct_q          <= PCT_RST;
			chg_q          <= 1'b0;
			stamp_q        <= '0;
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WEIGHT:    weight_q    <= cfg_data[WEIGHT_W-1:0];
					REG_USB_LIMIT: usb_limit_q <= cfg_data[MV_W-1:0];
					REG_HOLD:      hold_q      <= cfg_data[HOLD_W-1:0];
					default: ;
				endcase
			end
			// state moves exactly once per item, as it leaves its stage
			if (adv_s1) begin
				sv_q    <= sv_next;
				chg_q   <= chg_now;
				stamp_q <= stamp_next;
			end
			if (adv_s2) pct_q <= pct_next;

			if (take) valid_s1 <= 1'b1;
			else if (adv_s1) valid_s1 <= 1'b0;

			if (adv_s1) valid_s2 <= 1'b1;
			else if (adv_s2) valid_s2 <= 1'b0;

			if (adv_s2) result_valid_q <= 1'b1;
			else if (out_load) result_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) samp_s1 <= sample;
		if (adv_s1) begin
			gauge_s2.mv       <= sv_next[SV_W-1:FRAC_BITS];
			gauge_s2.charging <= chg_now;
			gauge_s2.hold     <= hold_now;
		end
		if (adv_s2) begin
			result_q.shown_percent  <= pct_next;
			result_q.charging_shown <= gauge_s2.charging;
			result_q.smoothed_mv    <= gauge_s2.mv;
		end
	end

endmodule
